### rtl/nrf_pkg.sv
// Shared types, constants and the arctangent table of the nearest-return follow controller.
// Used by every module of the block; depends on nothing.
package nrf_pkg;

    localparam int MAX_SAMPLES_DEF  = 4096;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_START   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_INIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_BAND     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_BAND     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIN_GAIN      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANG_GAIN      = 3'd7;

    localparam logic signed [19:0] RST_ANGLE_START  = -20'sd205887;
    localparam logic [15:0]        RST_ANGLE_STEP   = 16'd1144;
    localparam logic [12:0]        RST_SAMPLE_COUNT = 13'd360;
    localparam logic [15:0]        RST_RANGE_INIT   = 16'd10000;
    localparam logic [15:0]        RST_DEAD_BAND    = 16'd200;
    localparam logic [15:0]        RST_STOP_BAND    = 16'd300;
    localparam logic [15:0]        RST_LIN_GAIN     = 16'd51;
    localparam logic [15:0]        RST_ANG_GAIN     = 16'd102;

    localparam logic [15:0] NO_RETURN = 16'hFFFF;

    localparam logic signed [19:0] PI_ANG     = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_ANG = 20'sd411775;

    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [29:0]        INV_K_Q30   = 30'd652032874;

    typedef struct packed {
        logic [15:0]        nearest;
        logic               found;
        logic signed [19:0] angle;
    } t_job;

    typedef struct packed {
        logic [15:0]        linear_cmd;
        logic signed [19:0] angular_cmd;
        logic [15:0]        nearest_mm;
        logic signed [16:0] forward_offset_mm;
    } t_res;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/nearest_return_follow_controller.sv
// Top level of the nearest-return follow controller: configuration registers and queues.
// Depends on nrf_pkg, nrf_queue, nrf_front and nrf_back.
//
// Range samples enter through push/full; one transfer is taken at each edge with push
// high and full low. Every sample is handled by the front end, which keeps
// the nearest return of the scan and its angle. The sample marked scan_last places a job
// in a two-entry queue and the scan counter starts over.
// The back end takes one job at a time and steps through setup, the CORDIC rotations (one
// rotation per cycle in a single CORDIC unit), rounding, band decision and output; it
// takes no new job until the last one is written to the result queue.
// Results wait in a two-entry queue and are read through empty/pop. While the reader
// stalls, samples are still taken; full rises whenever the job queue holds two scans the
// back end has not taken, either because results back up or because short scans end
// faster than the back end can handle them.
// Registers are written through i_cfg_valid/o_cfg_ready, which is always ready; the user
// must write them only while no scan is in flight, which the block does not enforce.
// Reset, synchronous and active low, restores the register defaults, clears the scan
// counter, the held commands and the target angle, and empties both queues.
module nearest_return_follow_controller #(
    parameter int MAX_SAMPLES  = nrf_pkg::MAX_SAMPLES_DEF,
    parameter int CORDIC_STEPS = nrf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [15:0]                     i_range_mm,
    input  logic                            i_scan_last,
    output logic                            empty,
    input  logic                            pop,
    output logic [15:0]                     o_linear_cmd,
    output logic signed [19:0]              o_angular_cmd,
    output logic [15:0]                     o_nearest_mm,
    output logic signed [16:0]              o_forward_offset_mm,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nrf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [nrf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    logic signed [19:0] r_angle_start;
    logic [15:0]        r_angle_step;
    logic [12:0]        r_sample_count;
    logic [15:0]        r_range_init_mm;
    logic [15:0]        r_dead_band_mm;
    logic [15:0]        r_stop_band_mm;
    logic [15:0]        r_lin_gain_q8;
    logic [15:0]        r_ang_gain_q8;

    logic          accept;
    logic          job_push;
    nrf_pkg::t_job job_in;
    nrf_pkg::t_job job_out;
    logic          job_full;
    logic          job_empty;
    logic          job_pop;
    logic          res_push;
    logic          res_full;
    nrf_pkg::t_res res_in;
    nrf_pkg::t_res res_out;

    assign o_cfg_ready = 1'b1;
    assign full        = job_full;
    assign accept      = push && !job_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start   <= nrf_pkg::RST_ANGLE_START;
            r_angle_step    <= nrf_pkg::RST_ANGLE_STEP;
            r_sample_count  <= nrf_pkg::RST_SAMPLE_COUNT;
            r_range_init_mm <= nrf_pkg::RST_RANGE_INIT;
            r_dead_band_mm  <= nrf_pkg::RST_DEAD_BAND;
            r_stop_band_mm  <= nrf_pkg::RST_STOP_BAND;
            r_lin_gain_q8   <= nrf_pkg::RST_LIN_GAIN;
            r_ang_gain_q8   <= nrf_pkg::RST_ANG_GAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                nrf_pkg::CFG_ANGLE_START:  r_angle_start   <= signed'(i_cfg_data[19:0]);
                nrf_pkg::CFG_ANGLE_STEP:   r_angle_step    <= i_cfg_data[15:0];
                nrf_pkg::CFG_SAMPLE_COUNT: r_sample_count  <= i_cfg_data[12:0];
                nrf_pkg::CFG_RANGE_INIT:   r_range_init_mm <= i_cfg_data[15:0];
                nrf_pkg::CFG_DEAD_BAND:    r_dead_band_mm  <= i_cfg_data[15:0];
                nrf_pkg::CFG_STOP_BAND:    r_stop_band_mm  <= i_cfg_data[15:0];
                nrf_pkg::CFG_LIN_GAIN:     r_lin_gain_q8   <= i_cfg_data[15:0];
                nrf_pkg::CFG_ANG_GAIN:     r_ang_gain_q8   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    nrf_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_range_mm     (i_range_mm),
        .i_scan_last    (i_scan_last),
        .i_angle_start  (r_angle_start),
        .i_angle_step   (r_angle_step),
        .i_sample_count (r_sample_count),
        .i_range_init_mm(r_range_init_mm),
        .o_job_push     (job_push),
        .o_job          (job_in)
    );

    nrf_queue #(
        .WIDTH($bits(nrf_pkg::t_job))
    ) u_job_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .o_full (job_full),
        .i_pop  (job_pop),
        .o_empty(job_empty),
        .o_data (job_out)
    );

    nrf_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (job_empty),
        .i_job         (job_out),
        .o_job_pop     (job_pop),
        .i_out_full    (res_full),
        .o_out_push    (res_push),
        .o_out         (res_in),
        .i_dead_band_mm(r_dead_band_mm),
        .i_stop_band_mm(r_stop_band_mm),
        .i_lin_gain_q8 (r_lin_gain_q8),
        .i_ang_gain_q8 (r_ang_gain_q8)
    );

    nrf_queue #(
        .WIDTH($bits(nrf_pkg::t_res))
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (res_out)
    );

    assign o_linear_cmd        = res_out.linear_cmd;
    assign o_angular_cmd       = res_out.angular_cmd;
    assign o_nearest_mm        = res_out.nearest_mm;
    assign o_forward_offset_mm = res_out.forward_offset_mm;

endmodule

### rtl/nrf_queue.sv
// Two-entry first-in first-out queue used between the stages of the controller.
// Depends on nrf_pkg for its depth.
module nrf_queue #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int DEPTH = nrf_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("queue count did not drop after a pop");

endmodule

### rtl/nrf_front.sv
// Sample front end: tracks the nearest return of the scan and its angle.
// Depends on nrf_pkg; hands one job per scan to the back end.
module nrf_front #(
    parameter int MAX_SAMPLES = nrf_pkg::MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [15:0]        i_range_mm,
    input  logic               i_scan_last,
    input  logic signed [19:0] i_angle_start,
    input  logic [15:0]        i_angle_step,
    input  logic [12:0]        i_sample_count,
    input  logic [15:0]        i_range_init_mm,
    output logic               o_job_push,
    output nrf_pkg::t_job      o_job
);
    localparam int IW = $clog2(MAX_SAMPLES + 1);
    localparam int CW = (IW > 13) ? IW : 13;

    logic [IW-1:0]      r_index;
    logic [15:0]        r_nearest;
    logic               r_found;
    logic signed [19:0] r_angle;

    logic               first;
    logic [15:0]        cur;
    logic               found;
    logic               in_window;
    logic               take;
    logic [IW+15:0]     prod;
    logic signed [19:0] samp_angle;
    logic [15:0]        n_nearest;
    logic               n_found;
    logic signed [19:0] n_angle;
    logic [IW-1:0]      n_index;

    always_comb begin
        first      = (r_index == '0);
        cur        = first ? i_range_init_mm : r_nearest;
        found      = first ? 1'b0 : r_found;
        in_window  = (CW'(r_index) < CW'(i_sample_count)) && (r_index != IW'(MAX_SAMPLES));
        take       = in_window && (i_range_mm != nrf_pkg::NO_RETURN) && (i_range_mm < cur);
        prod       = (IW + 16)'(r_index) * (IW + 16)'(i_angle_step);
        samp_angle = i_angle_start + signed'(prod[19:0]);
        n_nearest  = take ? i_range_mm : cur;
        n_found    = found || take;
        n_angle    = take ? samp_angle : r_angle;
        if (i_scan_last) begin
            n_index = '0;
        end else if (r_index != IW'(MAX_SAMPLES)) begin
            n_index = r_index + 1'b1;
        end else begin
            n_index = r_index;
        end
    end

    assign o_job_push    = i_accept && i_scan_last;
    assign o_job.nearest = n_nearest;
    assign o_job.found   = n_found;
    assign o_job.angle   = n_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_found <= 1'b0;
        end else if (i_accept) begin
            r_index   <= n_index;
            r_found   <= n_found;
            r_nearest <= n_nearest;
            r_angle   <= n_angle;
        end
    end

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= IW'(MAX_SAMPLES))
        else $error("sample index beyond its saturation value");

endmodule

### rtl/nrf_back.sv
// Command back end: CORDIC forward offset, band decisions and proportional commands.
// Depends on nrf_pkg; takes jobs from the front queue and fills the result queue.
module nrf_back #(
    parameter int CORDIC_STEPS = nrf_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_empty,
    input  nrf_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_out_full,
    output logic          o_out_push,
    output nrf_pkg::t_res o_out,
    input  logic [15:0]   i_dead_band_mm,
    input  logic [15:0]   i_stop_band_mm,
    input  logic [15:0]   i_lin_gain_q8,
    input  logic [15:0]   i_ang_gain_q8
);
    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_FOLD, S_ITER, S_ROUND, S_CTRL, S_OUT} t_state;
    typedef enum logic [1:0] {M_AHEAD, M_BEHIND, M_ZERO} t_mode;

    t_state             r_state;
    t_mode              r_mode;
    logic [SW-1:0]      r_step;
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;
    logic signed [34:0] r_z;
    logic               r_neg;
    logic [15:0]        r_near;
    logic signed [19:0] r_tgt;
    logic signed [16:0] r_off;
    logic signed [33:0] r_lin_p;
    logic signed [36:0] r_ang_p;
    logic [15:0]        r_held_lin;
    logic signed [19:0] r_held_ang;

    logic signed [19:0] start_angle;
    logic signed [34:0] z0;
    logic signed [34:0] z_red;
    logic [45:0]        x_init;
    logic signed [34:0] atan_z;
    logic signed [47:0] x_sh;
    logic signed [47:0] y_sh;
    logic signed [47:0] n_x;
    logic signed [47:0] n_y;
    logic signed [34:0] n_z;
    logic signed [47:0] x_rnd;
    logic signed [17:0] res18;
    logic signed [18:0] res19;
    logic signed [16:0] off_sat;
    logic signed [17:0] off18;
    logic signed [17:0] dead18;
    logic signed [17:0] stop18;
    logic               ahead;
    logic               behind;
    logic signed [19:0] tgt_wrap;
    logic signed [33:0] lin_prod;
    logic signed [36:0] ang_prod;
    logic signed [33:0] lin_rnd;
    logic signed [36:0] ang_rnd;
    logic [15:0]        n_held_lin;
    logic signed [19:0] n_held_ang;

    always_comb begin
        start_angle = i_job.found ? i_job.angle : r_tgt;
        z0          = {start_angle[19], start_angle, 14'b0};
        if (z0 > nrf_pkg::PI_Q30) begin
            z_red = z0 - nrf_pkg::TWO_PI_Q30;
        end else if (z0 < -nrf_pkg::PI_Q30) begin
            z_red = z0 + nrf_pkg::TWO_PI_Q30;
        end else begin
            z_red = z0;
        end
        x_init = 46'(i_job.nearest) * 46'(nrf_pkg::INV_K_Q30);

        atan_z = signed'({5'b0, nrf_pkg::atan_q30(5'(r_step))});
        x_sh   = r_x >>> r_step;
        y_sh   = r_y >>> r_step;
        if (r_z >= 0) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_z;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_z;
        end

        x_rnd = r_x + 48'sd536870912;
        res18 = x_rnd[47:30];
        res19 = r_neg ? -19'(res18) : 19'(res18);
        if (res19 > 19'sd65535) begin
            off_sat = 17'sd65535;
        end else if (res19 < -19'sd65535) begin
            off_sat = -17'sd65535;
        end else begin
            off_sat = res19[16:0];
        end

        off18    = 18'(r_off);
        dead18   = signed'({2'b00, i_dead_band_mm});
        stop18   = signed'({2'b00, i_stop_band_mm});
        ahead    = (off18 > dead18) && (off18 > stop18);
        behind   = off18 < -dead18;
        tgt_wrap = (r_tgt > nrf_pkg::PI_ANG) ? r_tgt - nrf_pkg::TWO_PI_ANG : r_tgt;
        lin_prod = 34'(r_off) * 34'(signed'({1'b0, i_lin_gain_q8}));
        ang_prod = 37'(tgt_wrap) * 37'(signed'({1'b0, i_ang_gain_q8}));

        lin_rnd = (r_lin_p + 34'sd128) >>> 8;
        ang_rnd = (r_ang_p + 37'sd128) >>> 8;
        n_held_lin = r_held_lin;
        n_held_ang = r_held_ang;
        case (r_mode)
            M_AHEAD: begin
                n_held_lin = (lin_rnd > 34'sd65535) ? 16'hFFFF : lin_rnd[15:0];
                if (ang_rnd > 37'sd524287) begin
                    n_held_ang = 20'sd524287;
                end else if (ang_rnd < -37'sd524288) begin
                    n_held_ang = -20'sd524288;
                end else begin
                    n_held_ang = ang_rnd[19:0];
                end
            end
            M_BEHIND: begin
                n_held_ang = r_tgt;
            end
            default: begin
                n_held_lin = '0;
                n_held_ang = '0;
            end
        endcase
    end

    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty && !i_out_full;
    assign o_out_push = (r_state == S_OUT);
    assign o_out.linear_cmd        = n_held_lin;
    assign o_out.angular_cmd       = n_held_ang;
    assign o_out.nearest_mm        = r_near;
    assign o_out.forward_offset_mm = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_tgt      <= '0;
            r_held_lin <= '0;
            r_held_ang <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_tgt   <= start_angle;
                        r_near  <= i_job.nearest;
                        r_x     <= signed'({2'b00, x_init});
                        r_y     <= '0;
                        r_z     <= z_red;
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (r_z > nrf_pkg::HALF_PI_Q30) begin
                        r_z   <= r_z - nrf_pkg::PI_Q30;
                        r_neg <= 1'b1;
                    end else if (r_z < -nrf_pkg::HALF_PI_Q30) begin
                        r_z   <= r_z + nrf_pkg::PI_Q30;
                        r_neg <= 1'b1;
                    end else begin
                        r_neg <= 1'b0;
                    end
                    r_step  <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    if (r_step == SW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_ROUND;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ROUND: begin
                    r_off   <= off_sat;
                    r_state <= S_CTRL;
                end
                S_CTRL: begin
                    r_lin_p <= lin_prod;
                    r_ang_p <= ang_prod;
                    if (ahead) begin
                        r_mode <= M_AHEAD;
                        r_tgt  <= tgt_wrap;
                    end else if (behind) begin
                        r_mode <= M_BEHIND;
                        r_tgt  <= tgt_wrap;
                    end else begin
                        r_mode <= M_ZERO;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_held_lin <= n_held_lin;
                    r_held_ang <= n_held_ang;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= SW'(CORDIC_STEPS - 1))
        else $error("rotation counter beyond the last step");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !i_out_full)
        else $error("result written while the result queue is full");

endmodule
